[hdl/json_number_recognizer_unit_assert.svh]
// ----------------------------------------------------------------------------
// JSON number recognizer assertion macros
// Shorthand for the concurrent checks on the recognizer ports.
// ----------------------------------------------------------------------------
`ifndef JSON_NUMBER_RECOGNIZER_UNIT_ASSERT_SVH
`define JSON_NUMBER_RECOGNIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JNR_ASSERT_IMPLY(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JNR_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/jnr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number recognizer package
// Types and constants shared by the recognizer modules.
// ----------------------------------------------------------------------------
package jnr_pkg;

    localparam int unsigned MaxLengthDefault = 255;
    localparam int unsigned LenW = 8;
    localparam int unsigned ByteW = 8;

    typedef enum logic [2:0] {
        CLS_ZERO    = 3'd0,
        CLS_NZDIGIT = 3'd1,
        CLS_DOT     = 3'd2,
        CLS_EXP     = 3'd3,
        CLS_PLUS    = 3'd4,
        CLS_MINUS   = 3'd5,
        CLS_TERM    = 3'd6,
        CLS_OTHER   = 3'd7
    } char_class_t;

    typedef enum logic [3:0] {
        ST_INIT     = 4'd0,
        ST_NEG      = 4'd1,
        ST_ZERO     = 4'd2,
        ST_INT      = 4'd3,
        ST_DOT      = 4'd4,
        ST_FRAC     = 4'd5,
        ST_EXP_SIGN = 4'd6,
        ST_EXP_MARK = 4'd7,
        ST_EXP_DIG  = 4'd8,
        ST_DONE     = 4'd9,
        ST_NONE     = 4'd10,
        ST_ERR      = 4'd11
    } acc_state_t;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_NONE   = 2'd1,
        STAT_ERROR  = 2'd2
    } status_t;

    typedef struct packed {
        logic        valid;
        char_class_t cls;
        logic        restart;
    } stage_t;

endpackage

[hdl/jnr_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number recognizer input stage
// Classifies each text byte and holds the class and restart flag in a register.
// ----------------------------------------------------------------------------
module jnr_in_stage
    import jnr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ByteW-1:0]   text_byte,
    input  logic               restart,
    input  logic               advance,
    output stage_t             stage
);

    logic        valid_reg;
    logic        valid_next;
    char_class_t cls_reg;
    logic        restart_reg;
    char_class_t cls_comb;
    logic        take;

    always_comb
    begin
        if (text_byte == 8'h30) begin
            cls_comb = CLS_ZERO;
        end else if (text_byte inside {[8'h31:8'h39]}) begin
            cls_comb = CLS_NZDIGIT;
        end else if (text_byte == 8'h2E) begin
            cls_comb = CLS_DOT;
        end else if (text_byte inside {8'h45, 8'h65}) begin
            cls_comb = CLS_EXP;
        end else if (text_byte == 8'h2B) begin
            cls_comb = CLS_PLUS;
        end else if (text_byte == 8'h2D) begin
            cls_comb = CLS_MINUS;
        end else if (text_byte inside {8'h00, 8'h20, 8'h0A, 8'h0D, 8'h5D, 8'h2C, 8'h7D}) begin
            cls_comb = CLS_TERM;
        end else begin
            cls_comb = CLS_OTHER;
        end
    end

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            cls_reg     <= cls_comb;
            restart_reg <= restart;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.cls     = cls_reg;
    assign stage.restart = restart_reg;

endmodule

[hdl/jnr_acceptor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number recognizer acceptor
// Steps the number acceptor and length count, and holds the result register.
// ----------------------------------------------------------------------------
module jnr_acceptor
    import jnr_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MaxLengthDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  stage_t          stage,
    output logic            advance,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output logic [LenW-1:0] consumed_length
);

    localparam logic [LenW-1:0] LenLimit =
        (MAX_LENGTH > 255) ? 8'd255 : LenW'(MAX_LENGTH);

    acc_state_t      state_reg;
    acc_state_t      state_next;
    logic [LenW-1:0] count_reg;
    logic [LenW-1:0] count_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    status_t         status_reg;
    logic [LenW-1:0] length_reg;
    acc_state_t      cur;
    acc_state_t      nxt;
    logic [LenW-1:0] cnt;
    logic            digit;
    logic            terminal;
    status_t         stat_comb;

    assign cur   = stage.restart ? ST_INIT : state_reg;
    assign cnt   = stage.restart ? '0 : count_reg;
    assign digit = (stage.cls == CLS_ZERO) || (stage.cls == CLS_NZDIGIT);

    always_comb
    begin
        case (cur)
            ST_NEG:
            begin
                if (stage.cls == CLS_ZERO) nxt = ST_ZERO;
                else if (digit) nxt = ST_INT;
                else nxt = ST_ERR;
            end
            ST_ZERO:
            begin
                if (stage.cls == CLS_DOT) nxt = ST_DOT;
                else if (stage.cls == CLS_EXP) nxt = ST_EXP_MARK;
                else if (stage.cls == CLS_TERM) nxt = ST_DONE;
                else nxt = ST_ERR;
            end
            ST_INT:
            begin
                if (digit) nxt = ST_INT;
                else if (stage.cls == CLS_DOT) nxt = ST_DOT;
                else if (stage.cls == CLS_EXP) nxt = ST_EXP_MARK;
                else if (stage.cls == CLS_TERM) nxt = ST_DONE;
                else nxt = ST_ERR;
            end
            ST_DOT:
            begin
                if (digit) nxt = ST_FRAC;
                else if (stage.cls == CLS_TERM) nxt = ST_DONE;
                else nxt = ST_ERR;
            end
            ST_FRAC:
            begin
                if (digit) nxt = ST_FRAC;
                else if (stage.cls == CLS_EXP) nxt = ST_EXP_MARK;
                else if (stage.cls == CLS_TERM) nxt = ST_DONE;
                else nxt = ST_ERR;
            end
            ST_EXP_MARK:
            begin
                if (stage.cls == CLS_PLUS || stage.cls == CLS_MINUS) nxt = ST_EXP_SIGN;
                else if (digit) nxt = ST_EXP_DIG;
                else nxt = ST_ERR;
            end
            ST_EXP_SIGN:
            begin
                if (digit) nxt = ST_EXP_DIG;
                else nxt = ST_ERR;
            end
            ST_EXP_DIG:
            begin
                if (digit) nxt = ST_EXP_DIG;
                else if (stage.cls == CLS_TERM) nxt = ST_DONE;
                else nxt = ST_ERR;
            end
            default:
            begin
                if (stage.cls == CLS_MINUS) nxt = ST_NEG;
                else if (stage.cls == CLS_ZERO) nxt = ST_ZERO;
                else if (stage.cls == CLS_NZDIGIT) nxt = ST_INT;
                else nxt = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (nxt)
            ST_DONE: stat_comb = STAT_ACCEPT;
            ST_NONE: stat_comb = STAT_NONE;
            default: stat_comb = STAT_ERROR;
        endcase
    end

    assign terminal = (nxt == ST_DONE) || (nxt == ST_NONE) || (nxt == ST_ERR);
    assign advance  = stage.valid && (!terminal || !out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance) begin
            if (terminal) begin
                state_next     = ST_INIT;
                count_next     = '0;
                out_valid_next = 1'b1;
            end else begin
                state_next = nxt;
                count_next = (cnt < LenLimit) ? cnt + 1'b1 : cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && terminal) begin
            status_reg <= stat_comb;
            length_reg <= cnt;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign consumed_length = length_reg;

endmodule

[hdl/json_number_recognizer_unit.sv]
// The ending byte goes through the input register, then the result register.
// Throughput: one byte per cycle; the input register and the result register let
// the input keep flowing while a result waits, and only a second result stalls it.
// Reset: rst_n clears the acceptor to its initial state, the count to zero and
// both valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number recognizer
// Recognizes JSON-style numbers in a byte stream and reports status and length.
// ----------------------------------------------------------------------------
module json_number_recognizer_unit
    import jnr_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MaxLengthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ByteW-1:0] text_byte,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [LenW-1:0]  consumed_length
);

    stage_t stage;
    logic   advance;

    jnr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .restart   (restart),
        .advance   (advance),
        .stage     (stage)
    );

    jnr_acceptor #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_acceptor (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage           (stage),
        .advance         (advance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .consumed_length (consumed_length)
    );

endmodule

[hdl/jnr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number recognizer checker
// Port-level checks on the recognizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "json_number_recognizer_unit_assert.svh"

module jnr_checker
    import jnr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [1:0]      status,
    input logic [LenW-1:0] consumed_length
);

    `JNR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(consumed_length), "result item changed while stalled")
    `JNR_ASSERT_IMPLY(a_status_legal, clk, rst_n, out_valid, status != 2'd3, "illegal status code")
    `JNR_ASSERT_IMPLY(a_none_empty, clk, rst_n, out_valid && status == STAT_NONE, consumed_length == '0, "no-number result with nonzero length")
    `JNR_ASSERT_IMPLY(a_rise_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result item without an accepted byte")

endmodule

bind json_number_recognizer_unit jnr_checker u_jnr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .consumed_length (consumed_length)
);
